// ===== hw/rtl/fpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int P_MAX_PAYLOAD = 32;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 7;
    localparam int IDX_W         = 6;
    localparam logic [BYTE_W-1:0] LEN_MIN = 8'd2;

    typedef enum logic [2:0] {
        PH_SRC  = 3'd0,
        PH_LEN  = 3'd1,
        PH_DST  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4
    } t_phase;

    // frame header handed from parser to drain on a good checksum
    typedef struct packed {
        logic [BYTE_W-1:0] src;
        logic [BYTE_W-1:0] dst;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  size;
    } t_frame_info;

    typedef struct packed {
        logic [BYTE_W-1:0] src;
        logic [BYTE_W-1:0] dst;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] payload;
        logic [IDX_W-1:0]  idx;
        logic              has_payload;
        logic              last;
    } t_result;

endpackage

// ===== hw/rtl/fpp_payload_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_payload_ram
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpp_payload_ram import fpp_pkg::*; #(
    parameter int DEPTH = P_MAX_PAYLOAD,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fpp_rx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_rx_parser
// Byte-serial frame state machine: header capture, payload write, checksum.
// ----------------------------------------------------------------------------
module fpp_rx_parser import fpp_pkg::*; #(
    parameter int MAX_PAYLOAD = P_MAX_PAYLOAD,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output logic              o_start,
    output t_frame_info       o_info
);

    localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_PAYLOAD + 2);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_src, n_src;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_dst, n_dst;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [LEN_W-1:0]  w_size;
    logic [LEN_W-1:0]  w_cnt_inc;

    assign w_size    = r_len - LEN_W'(2);
    assign w_cnt_inc = r_cnt + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SRC;
            r_src   <= '0;
            r_len   <= '0;
            r_dst   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_src   <= n_src;
            r_len   <= n_len;
            r_dst   <= n_dst;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_src     = r_src;
        n_len     = r_len;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_xor     = r_xor;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[AW-1:0];
        o_wr_data = i_byte;
        o_start   = 1'b0;
        o_info    = '{src: r_src, dst: r_dst, len: r_len, size: w_size};
        if (i_byte_valid) begin
            case (r_phase)
                PH_LEN: begin
                    // out-of-range length restarts with this byte as source
                    if (i_byte < LEN_MIN || i_byte > LEN_MAX) begin
                        n_src = i_byte;
                        n_xor = i_byte;
                    end else begin
                        n_len   = i_byte[LEN_W-1:0];
                        n_xor   = r_xor ^ i_byte;
                        n_phase = PH_DST;
                    end
                end
                PH_DST: begin
                    n_dst   = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_cnt   = '0;
                    n_phase = (r_len > LEN_W'(2)) ? PH_DATA : PH_CHK;
                end
                PH_DATA: begin
                    o_wr_en = 1'b1;
                    n_cnt   = w_cnt_inc;
                    n_xor   = r_xor ^ i_byte;
                    if (w_cnt_inc >= w_size) begin
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    o_start = (i_byte == r_xor);
                    n_phase = PH_SRC;
                    n_src   = '0;
                    n_len   = '0;
                    n_dst   = '0;
                    n_cnt   = '0;
                    n_xor   = '0;
                end
                default: begin
                    n_src   = i_byte;
                    n_xor   = i_byte;
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/fpp_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_drain
// Reads the stored payload back in order and feeds the result register.
// ----------------------------------------------------------------------------
module fpp_drain import fpp_pkg::*; #(
    parameter int MAX_PAYLOAD = P_MAX_PAYLOAD,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_frame_info       i_info,
    output logic              o_busy,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [BYTE_W-1:0] i_rdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out
);

    logic             r_busy, n_busy;
    logic             r_empty, n_empty;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_frame_info      r_info, n_info;
    logic [LEN_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_pend_last, n_pend_last;
    t_result          r_out, n_out;

    logic w_out_free, w_load_pay, w_load_empty, w_issue;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_load_pay   = r_pend && w_out_free;
    assign w_load_empty = r_busy && r_empty && w_out_free;
    // read slot is free when nothing waits or the waiting byte moves on now
    assign w_issue      = r_busy && !r_empty && (r_rd_idx < r_info.size) &&
                          (!r_pend || w_out_free);

    assign o_busy      = r_busy;
    assign o_re        = w_issue;
    assign o_raddr     = r_rd_idx[AW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_empty     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_empty     <= n_empty;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_info      <= n_info;
        r_rd_idx    <= n_rd_idx;
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    always_comb begin
        n_busy      = r_busy;
        n_empty     = r_empty;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_info      = r_info;
        n_rd_idx    = r_rd_idx;
        n_pend_idx  = r_pend_idx;
        n_pend_last = r_pend_last;
        n_out       = r_out;

        if (w_load_pay) begin
            n_out_valid = 1'b1;
            n_out = '{src: r_info.src, dst: r_info.dst, len: r_info.len,
                      payload: i_rdata, idx: r_pend_idx, has_payload: 1'b1,
                      last: r_pend_last};
        end else if (w_load_empty) begin
            n_out_valid = 1'b1;
            n_out = '{src: r_info.src, dst: r_info.dst, len: r_info.len,
                      payload: '0, idx: '0, has_payload: 1'b0, last: 1'b1};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_start) begin
            n_busy   = 1'b1;
            n_info   = i_info;
            n_empty  = (i_info.size == '0);
            n_rd_idx = '0;
            n_pend   = 1'b0;
        end else if (r_empty) begin
            if (w_load_empty) begin
                n_empty = 1'b0;
                n_busy  = 1'b0;
            end
        end else begin
            if (w_issue) begin
                n_pend      = 1'b1;
                n_pend_idx  = r_rd_idx[IDX_W-1:0];
                n_pend_last = (LEN_W'(r_rd_idx + LEN_W'(1)) == r_info.size);
                n_rd_idx    = r_rd_idx + LEN_W'(1);
            end else if (w_load_pay) begin
                n_pend = 1'b0;
            end
            if (r_busy && !n_pend && n_rd_idx == r_info.size) begin
                n_busy = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/xor_checked_frame_parser_core.sv =====
`timescale 1ns / 1ps
// First result: drain start register, store read register, then result register;
// an empty frame skips the store read. Throughput: 1 byte per cycle while parsing;
// after a good checksum the payload store is read back at 1 entry per cycle while
// the receiver accepts results, and input stalls until the last result is loaded.
// Reset: synchronous, active low; clears parser and drain control, not the store.
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_core
// Source/length/destination/payload/XOR-checksum frame receiver.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_core import fpp_pkg::*; #(
    parameter int MAX_PAYLOAD = P_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] source_addr, [15:8] dest_addr, [22:16] length_field,
    // [30:23] payload_byte, [36:31] byte_index, [39:37] zero
    output logic [39:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // [0] has_payload
    output logic        m_axis_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              w_in_xfer;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_start;
    t_frame_info       w_info;
    logic              w_busy;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [BYTE_W-1:0] w_rdata;
    t_result           w_out;

    assign s_axis_tready = !w_busy;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    fpp_rx_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_in_xfer),
        .i_byte       (s_axis_tdata),
        .o_wr_en      (w_we),
        .o_wr_addr    (w_waddr),
        .o_wr_data    (w_wdata),
        .o_start      (w_start),
        .o_info       (w_info)
    );

    fpp_payload_ram #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fpp_drain #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_info      (w_info),
        .o_busy      (w_busy),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {3'b000, w_out.idx, w_out.payload, w_out.len,
                           w_out.dst, w_out.src};
    assign m_axis_tuser = w_out.has_payload;
    assign m_axis_tlast = w_out.last;

endmodule

// ===== tb/xor_checked_frame_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_core_tb
// Drives byte streams through the frame parser and tracks them with a
// cycle-free model of the parser. Directed frames cover empty and full
// payloads, bad checksums and rejected length bytes. Random traffic mixes
// good frames with noise, corrupted and cut-off frames under sender gaps and
// receiver stalls. Every output transfer is compared field by field.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_core_tb;
    import fpp_pkg::*;

    localparam int RANDOM_BYTES   = 270;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 20;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // parser model state
    t_phase      pr_phase = PH_SRC;
    logic [7:0]  pr_src   = '0;
    logic [7:0]  pr_len   = '0;
    logic [7:0]  pr_dst   = '0;
    logic [6:0]  pr_cnt   = '0;
    logic [7:0]  pr_xor   = '0;
    logic [7:0]  pr_store [P_MAX_PAYLOAD];

    t_result     exp_results [$];

    int          burst_left     = 0;
    int          bytes_sent     = 0;
    int          frames_sent    = 0;
    int          good_frames    = 0;
    int          full_frames    = 0;
    int          xfers_checked  = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          rx_cycle       = 0;
    int          rx_mode        = 0;

    xor_checked_frame_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_parse_state();
        pr_phase = PH_SRC;
        pr_src   = '0;
        pr_len   = '0;
        pr_dst   = '0;
        pr_cnt   = '0;
        pr_xor   = '0;
    endfunction

    // advances the parser model by one received byte, queues any frame output
    function automatic void parse_rx_byte(input logic [7:0] b);
        t_result     r;
        int unsigned size;
        case (pr_phase)
            PH_LEN: begin
                // rejected length byte restarts the frame with it as source
                if (b < LEN_MIN || b > P_MAX_PAYLOAD + 2) begin
                    pr_src = b;
                    pr_xor = b;
                end else begin
                    pr_len   = b;
                    pr_xor   = pr_xor ^ b;
                    pr_phase = PH_DST;
                end
            end
            PH_DST: begin
                pr_dst   = b;
                pr_xor   = pr_xor ^ b;
                pr_cnt   = '0;
                pr_phase = (pr_len > LEN_MIN) ? PH_DATA : PH_CHK;
            end
            PH_DATA: begin
                size = pr_len - LEN_MIN;
                if (pr_cnt < size) begin
                    pr_store[pr_cnt] = b;
                    pr_cnt = pr_cnt + 1;
                    pr_xor = pr_xor ^ b;
                end
                if (pr_cnt >= size) pr_phase = PH_CHK;
            end
            PH_CHK: begin
                if (b == pr_xor) begin
                    size = pr_len - LEN_MIN;
                    r.src = pr_src;
                    r.dst = pr_dst;
                    r.len = pr_len[6:0];
                    good_frames++;
                    if (size == P_MAX_PAYLOAD) full_frames++;
                    if (size == 0) begin
                        r.payload     = '0;
                        r.idx         = '0;
                        r.has_payload = 1'b0;
                        r.last        = 1'b1;
                        exp_results.push_back(r);
                    end else begin
                        for (int i = 0; i < size; i++) begin
                            r.payload     = pr_store[i];
                            r.idx         = i[IDX_W-1:0];
                            r.has_payload = 1'b1;
                            r.last        = (i + 1 == size);
                            exp_results.push_back(r);
                        end
                    end
                end
                clear_parse_state();
            end
            default: begin
                pr_src   = b;
                pr_xor   = b;
                pr_phase = PH_LEN;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // everything after the source byte; fill < 0 gives random payload bytes
    task automatic send_frame_body(input logic [7:0] src, input logic [7:0] dst,
                                   input int size, input int fill, input bit corrupt);
        logic [7:0] len;
        logic [7:0] csum;
        logic [7:0] pb;
        len  = 8'(size + 2);
        csum = src ^ len ^ dst;
        send_byte(len);
        send_byte(dst);
        for (int i = 0; i < size; i++) begin
            pb   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            csum = csum ^ pb;
            send_byte(pb);
        end
        if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
        send_byte(csum);
        frames_sent++;
    endtask

    task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                              input int size, input int fill, input bit corrupt);
        send_byte(src);
        send_frame_body(src, dst, size, fill, corrupt);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (exp_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_frame();
        send_frame(8'h00, 8'hFF, 0, -1, 1'b0);
        send_frame(8'hFF, 8'h00, 0, -1, 1'b0);
    endtask

    task automatic test_payload_extremes();
        send_frame(8'hA5, 8'h3C, 1, 8'hFF, 1'b0);
        send_frame(8'h5A, 8'hC3, 2, 8'h00, 1'b0);
        send_frame(8'h7E, 8'h81, P_MAX_PAYLOAD, -1, 1'b0);
    endtask

    task automatic test_bad_checksum();
        send_frame(8'h12, 8'h34, 3, -1, 1'b1);
        send_frame(8'h56, 8'h78, 0, -1, 1'b1);
        send_frame(8'h9A, 8'hBC, 1, -1, 1'b0);
    endtask

    task automatic test_length_out_of_range();
        // each rejected length byte becomes the new source
        send_byte(8'h44);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'(P_MAX_PAYLOAD + 3));
        send_byte(8'hFF);
        send_frame_body(8'hFF, 8'h21, 1, -1, 1'b0);
    endtask

    // pause the sender until every pending output has drained
    task automatic test_drain_pause();
        send_frame(8'hC0, 8'h0C, 4, -1, 1'b0);
        wait_for_drain();
        send_frame(8'h0F, 8'hF0, 0, -1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int target;
        int kind;
        int size;
        int cut;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 99);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, P_MAX_PAYLOAD)
                                               : $urandom_range(0, 8);
            if (kind < 70) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           size, -1, 1'b0);
            end else if (kind < 80) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           size, -1, 1'b1);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // frame cut off partway through its payload
                size = $urandom_range(2, 8);
                cut  = $urandom_range(0, size - 1);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'(size + 2));
                send_byte(8'($urandom_range(0, 255)));
                repeat (cut) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 39) == 0) wait_for_drain();
        end
    endtask

    // receiver stall pattern: a randomly picked mode sets m_axis_tready
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 50 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cycle % 50 >= 40);
        endcase
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            xfers_checked++;
            if (exp_results.size() == 0) begin
                $error("output transfer with no result pending");
                mismatch_count++;
            end else begin
                want = exp_results.pop_front();
                check_field("source_addr", want.src, m_axis_tdata[7:0]);
                check_field("dest_addr", want.dst, m_axis_tdata[15:8]);
                check_field("length_field", want.len, m_axis_tdata[22:16]);
                check_field("payload_byte", want.payload, m_axis_tdata[30:23]);
                check_field("byte_index", want.idx, m_axis_tdata[36:31]);
                check_field("tdata_pad", 0, m_axis_tdata[39:37]);
                check_field("has_payload", want.has_payload, m_axis_tuser[0]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_frame();
        test_payload_extremes();
        test_bad_checksum();
        test_length_out_of_range();
        test_drain_pause();
        test_random_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (exp_results.size() != 0) begin
            $error("%0d expected results never arrived", exp_results.size());
            mismatch_count++;
        end

        $display("Sent %0d bytes as %0d frames plus noise; %0d frames passed the checksum",
                 bytes_sent, frames_sent, good_frames);
        $display("(%0d with a full payload); %0d output transfers checked, %0d mismatches",
                 full_frames, xfers_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_payload_ram.sv
hw/rtl/fpp_rx_parser.sv
hw/rtl/fpp_drain.sv
hw/rtl/xor_checked_frame_parser_core.sv
tb/xor_checked_frame_parser_core_tb.sv
